### sv/xz_index_size_parser_top_macros.svh
// ----------------------------------------------------------------------------
// xz_index_size_parser_top_macros.svh
// Assertion macros shared by the checker of the index size parser.
// ----------------------------------------------------------------------------
`ifndef XZ_INDEX_SIZE_PARSER_TOP_MACROS_SVH
`define XZ_INDEX_SIZE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define XZISP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define XZISP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/xzisp_pkg.sv
// ----------------------------------------------------------------------------
// xzisp_pkg
// Types and constants of the index size parser.
// ----------------------------------------------------------------------------
`default_nettype none

package xzisp_pkg;

	localparam int MAX_VARINT_BYTES_DEF = 9;
	localparam int VALUE_W = 63;
	localparam int SUM_W = 64;
	// Queue between front and back; power of two.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_INDICATOR = 2'd0,
		PH_COUNT     = 2'd1,
		PH_RECORDS   = 2'd2,
		PH_DRAIN     = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_IND    = 2'd1,
		ST_BAD_VARINT = 2'd2,
		ST_TRUNC      = 2'd3
	} status_t;

	// Classified byte as handed from front to back.
	typedef struct packed {
		logic [6:0] grp;     // seven data bits
		logic       cont;    // continuation bit
		logic       is_zero; // whole byte is 0x00
		logic       last;    // final byte of the stream
	} item_t;

endpackage

`default_nettype wire

### sv/xzisp_front.sv
// ----------------------------------------------------------------------------
// xzisp_front
// Input stage: takes one byte per transaction, classifies and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module xzisp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_ready,
	input  wire logic [7:0]       index_byte,
	input  wire logic             last_byte,
	output logic                  item_valid,
	output xzisp_pkg::item_t      item,
	input  wire logic             item_ready
);

	logic             vld_s1;
	xzisp_pkg::item_t item_s1;

	assign byte_ready = !vld_s1 || item_ready;
	assign item_valid = vld_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ready) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1.grp     <= index_byte[6:0];
			item_s1.cont    <= index_byte[7];
			item_s1.is_zero <= (index_byte == 8'h00);
			item_s1.last    <= last_byte;
		end
	end

endmodule

`default_nettype wire

### sv/xzisp_queue.sv
// ----------------------------------------------------------------------------
// xzisp_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module xzisp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire xzisp_pkg::item_t push_item,
	output logic                  push_ready,
	output logic                  pop_valid,
	output xzisp_pkg::item_t      pop_item,
	input  wire logic             pop_ready
);

	localparam int DEPTH = xzisp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	xzisp_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### sv/xzisp_back.sv
// ----------------------------------------------------------------------------
// xzisp_back
// Parser: varint decode, record walk, size sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xzisp_back #(
	parameter int MAX_VARINT_BYTES = xzisp_pkg::MAX_VARINT_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	input  wire xzisp_pkg::item_t              item,
	output logic                               item_ready,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [xzisp_pkg::SUM_W-1:0]        total_size,
	output logic [xzisp_pkg::VALUE_W-1:0]      record_total,
	output logic [1:0]                         status
);

	localparam int VW   = xzisp_pkg::VALUE_W;
	localparam int SW   = xzisp_pkg::SUM_W;
	localparam int VB_W = $clog2(MAX_VARINT_BYTES + 1);
	localparam logic [VB_W-1:0] VB_MAX = VB_W'(MAX_VARINT_BYTES);

	// Put a 7-bit group at its place in the value.
	function automatic logic [VW-1:0] place_group(input logic [6:0] grp,
			input logic [VB_W-1:0] idx);
		logic [VW-1:0] res;
		res = '0;
		for (int k = 0; k < MAX_VARINT_BYTES; k++) begin
			if (idx == VB_W'(k)) begin
				res[7*k +: 7] = grp;
			end
		end
		return res;
	endfunction

	xzisp_pkg::phase_t  phase_q, phase_d;
	logic [VW-1:0]      vval_q, vval_d;
	logic [VB_W-1:0]    vbytes_q, vbytes_d;
	logic [VW-1:0]      rec_exp_q, rec_exp_d;
	logic [VW-1:0]      rec_done_q, rec_done_d;
	logic               half_q, half_d;
	logic [SW-1:0]      sum_q, sum_d;

	logic               result_valid_q;
	logic [SW-1:0]      total_q;
	logic [VW-1:0]      rec_total_q;
	xzisp_pkg::status_t status_q;

	logic               take;
	logic [VW-1:0]      acc;
	logic [VB_W-1:0]    vb_inc;
	logic               v_bad;
	logic [SW-1:0]      sum_add;
	logic [VW-1:0]      done_inc;
	logic               emit;
	xzisp_pkg::status_t emit_status;
	logic [SW-1:0]      emit_sum;
	logic [VW-1:0]      emit_count;

	assign item_ready = !result_valid_q || result_ready;
	assign take       = item_valid && item_ready;

	assign acc      = vval_q | place_group(item.grp, vbytes_q);
	assign vb_inc   = vbytes_q + VB_W'(1);
	assign v_bad    = (vbytes_q >= VB_MAX) || ((vbytes_q != '0) && item.is_zero) ||
		(item.cont && (vb_inc >= VB_MAX));
	assign sum_add  = sum_q + {1'b0, acc};
	assign done_inc = rec_done_q + VW'(1);

	always_comb begin
		phase_d     = phase_q;
		vval_d      = vval_q;
		vbytes_d    = vbytes_q;
		rec_exp_d   = rec_exp_q;
		rec_done_d  = rec_done_q;
		half_d      = half_q;
		sum_d       = sum_q;
		emit        = 1'b0;
		emit_status = xzisp_pkg::ST_OK;
		emit_sum    = '0;
		emit_count  = '0;
		if (take) begin
			case (phase_q)
				xzisp_pkg::PH_INDICATOR: begin
					if (!item.is_zero) begin
						emit        = 1'b1;
						emit_status = xzisp_pkg::ST_BAD_IND;
					end else begin
						phase_d  = xzisp_pkg::PH_COUNT;
						vval_d   = '0;
						vbytes_d = '0;
					end
				end
				xzisp_pkg::PH_COUNT, xzisp_pkg::PH_RECORDS: begin
					if (v_bad) begin
						emit        = 1'b1;
						emit_status = xzisp_pkg::ST_BAD_VARINT;
					end else if (!item.cont) begin
						vval_d   = '0;
						vbytes_d = '0;
						if (phase_q == xzisp_pkg::PH_COUNT) begin
							rec_exp_d  = acc;
							rec_done_d = '0;
							half_d     = 1'b0;
							if (acc == '0) begin
								emit       = 1'b1;
								emit_sum   = sum_q;
								emit_count = acc;
							end else begin
								phase_d = xzisp_pkg::PH_RECORDS;
							end
						end else begin
							// second integer of a record is the uncompressed size
							if (half_q) begin
								sum_d      = sum_add;
								rec_done_d = done_inc;
								if (done_inc == rec_exp_q) begin
									emit       = 1'b1;
									emit_sum   = sum_add;
									emit_count = rec_exp_q;
								end
							end
							half_d = !half_q;
						end
					end else begin
						vval_d   = acc;
						vbytes_d = vb_inc;
					end
				end
				default: begin
				end
			endcase
			// stream ended before a result
			if (!emit && item.last && (phase_q != xzisp_pkg::PH_DRAIN)) begin
				emit        = 1'b1;
				emit_status = xzisp_pkg::ST_TRUNC;
			end
			if (emit) begin
				phase_d = xzisp_pkg::PH_DRAIN;
			end
			if (item.last) begin
				phase_d    = xzisp_pkg::PH_INDICATOR;
				vval_d     = '0;
				vbytes_d   = '0;
				rec_exp_d  = '0;
				rec_done_d = '0;
				half_d     = 1'b0;
				sum_d      = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= xzisp_pkg::PH_INDICATOR;
			vval_q         <= '0;
			vbytes_q       <= '0;
			rec_exp_q      <= '0;
			rec_done_q     <= '0;
			half_q         <= 1'b0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			vval_q     <= vval_d;
			vbytes_q   <= vbytes_d;
			rec_exp_q  <= rec_exp_d;
			rec_done_q <= rec_done_d;
			half_q     <= half_d;
			sum_q      <= sum_d;
			if (take && emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			total_q     <= emit_sum;
			rec_total_q <= emit_count;
			status_q    <= emit_status;
		end
	end

	assign result_valid = result_valid_q;
	assign total_size   = total_q;
	assign record_total = rec_total_q;
	assign status       = status_q;

endmodule

`default_nettype wire

### sv/xz_index_size_parser_top.sv
// ----------------------------------------------------------------------------
// xz_index_size_parser_top
// Walks the index field of an XZ container and reports the uncompressed size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid/byte_ready): one index byte per transaction,
//   last_byte set on the final byte of a stream. After that byte the parser
//   is back at the indicator byte of a new stream.
//   Output channel (result_valid/result_ready): one transaction per stream,
//   carrying total_size, record_total and status (0 ok, 1 nonzero indicator,
//   2 malformed varint, 3 truncated stream). On an error the sizes read zero.
//   Bytes after a result are dropped up to and including last_byte.
// Timing:
//   One byte per cycle sustained while result_ready keeps up. The byte that
//   completes a result passes the input register and the queue; the parser
//   stage then loads the result register.
//   The front holds one byte, the queue four more. While a result waits on
//   result_ready the parser holds, the queue fills and byte_ready drops.
// Reset:
//   arst_n clears the parser state, the queue and both valid flags; the
//   block is ready for bytes as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module xz_index_size_parser_top #(
	parameter int MAX_VARINT_BYTES = xzisp_pkg::MAX_VARINT_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_valid,
	output logic                               byte_ready,
	input  wire logic [7:0]                    index_byte,
	input  wire logic                          last_byte,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [xzisp_pkg::SUM_W-1:0]        total_size,
	output logic [xzisp_pkg::VALUE_W-1:0]      record_total,
	output logic [1:0]                         status
);

	// front -> queue
	logic             fq_valid;
	logic             fq_ready;
	xzisp_pkg::item_t fq_item;

	// queue -> back
	logic             qb_valid;
	logic             qb_ready;
	xzisp_pkg::item_t qb_item;

	// Front: register the byte and split it into group, continuation,
	// zero flag and end of stream.
	xzisp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.index_byte (index_byte),
		.last_byte  (last_byte),
		.item_valid (fq_valid),
		.item       (fq_item),
		.item_ready (fq_ready)
	);

	// Queue decouples the input side from a stalled result register.
	xzisp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_item  (fq_item),
		.push_ready (fq_ready),
		.pop_valid  (qb_valid),
		.pop_item   (qb_item),
		.pop_ready  (qb_ready)
	);

	// Back: one byte per cycle through the varint decoder and the record
	// walk while no result waits on result_ready; the 64-bit size sum wraps.
	xzisp_back #(
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (qb_valid),
		.item         (qb_item),
		.item_ready   (qb_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.total_size   (total_size),
		.record_total (record_total),
		.status       (status)
	);

endmodule

`default_nettype wire

### sv/xzisp_checker.sv
// ----------------------------------------------------------------------------
// xzisp_checker
// Port-level checks of the index size parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xz_index_size_parser_top_macros.svh"

module xzisp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic [xzisp_pkg::SUM_W-1:0]   total_size,
	input wire logic [xzisp_pkg::VALUE_W-1:0] record_total,
	input wire logic [1:0]                    status
);

	logic res_stall;
	logic res_err;
	logic res_empty_ok;
	logic sizes_zero;
	logic [xzisp_pkg::SUM_W+xzisp_pkg::VALUE_W+1:0] res_word;

	assign res_stall    = result_valid && !result_ready;
	assign res_err      = result_valid && (status != xzisp_pkg::ST_OK);
	assign res_empty_ok = result_valid && (status == xzisp_pkg::ST_OK) && (record_total == '0);
	assign sizes_zero   = (total_size == '0) && (record_total == '0);
	assign res_word     = {total_size, record_total, status};

	// a stalled result transaction holds
	`XZISP_ASSERT_NEXT(a_res_hold, res_stall, result_valid && $stable(res_word), "result moved")
	// errors carry no sizes
	`XZISP_ASSERT_NOW(a_err_zero, res_err, sizes_zero, "error result carries sizes")
	// an index with no records sums to zero
	`XZISP_ASSERT_NOW(a_empty_sum, res_empty_ok, total_size == '0, "empty index total")

endmodule

bind xz_index_size_parser_top xzisp_checker u_xzisp_checker (.*);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XZ index size parser: streams of index bytes go
// in over valid/ready, and each result transaction is checked against an
// in-bench parser that tracks the same phase, varint and record state.
// ----------------------------------------------------------------------------

module tb;

	// ------------------------------------------------------------------------
	// Bench constants
	// ------------------------------------------------------------------------
	localparam int          SUM_W        = xzisp_pkg::SUM_W;
	localparam int          VALUE_W      = xzisp_pkg::VALUE_W;
	localparam int          VARINT_MAX   = xzisp_pkg::MAX_VARINT_BYTES_DEF;
	localparam int          BYTE_TARGET  = 925;     // directed + random bytes
	localparam int unsigned CYCLE_LIMIT  = 400000;  // watchdog bound on the run
	localparam int          DRAIN_CYCLES = 24;      // idle tail after the last result
	localparam logic [7:0]  IND_ZERO     = 8'h00;   // only legal indicator byte
	localparam logic [7:0]  CONT_BIT     = 8'h80;

	// Outcome of feeding one byte into the varint accumulator.
	typedef enum logic [1:0] {
		VB_MORE,
		VB_DONE,
		VB_BAD
	} vstep_t;

	// One byte waiting in the driver queue; hold makes the driver wait for
	// every outstanding result before presenting it.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hold;
	} index_beat_t;

	// One expected result transaction.
	typedef struct packed {
		logic [SUM_W-1:0]     total;
		logic [VALUE_W-1:0]   records;
		xzisp_pkg::status_t   st;
	} size_report_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                byte_valid   = 1'b0;
	logic                byte_ready;
	logic [7:0]          index_byte   = '0;
	logic                last_byte    = 1'b0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [SUM_W-1:0]    total_size;
	logic [VALUE_W-1:0]  record_total;
	logic [1:0]          status;

	xz_index_size_parser_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.index_byte   (index_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.total_size   (total_size),
		.record_total (record_total),
		.status       (status)
	);

	// ------------------------------------------------------------------------
	// Clock and reset: 20 ns period, reset released once
	// ------------------------------------------------------------------------
	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	index_beat_t  pending[$];       // bytes still to be driven
	logic [7:0]   stream_bytes[$];  // scratch buffer for building one stream
	size_report_t reports_due[$];   // expected results, oldest first
	size_report_t report_head;
	int           in_flight = 0;    // reports_due size as of the previous edge
	int           fail_count = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	logic         calm = 1'b0;      // both sides run without idling while set
	int unsigned  cycle_cnt = 0;

	// Parser mirror: phase, varint accumulator, record bookkeeping.
	xzisp_pkg::phase_t  parse_ph;
	logic [VALUE_W-1:0] acc_val;
	int                 acc_len;
	logic [VALUE_W-1:0] rec_want;
	logic [VALUE_W-1:0] rec_seen;
	logic               odd_field;  // set while reading the uncompressed size
	logic [SUM_W-1:0]   size_acc;
	logic               result_sent;

	// ------------------------------------------------------------------------
	// Parser mirror
	// ------------------------------------------------------------------------
	task automatic clear_parser();
		parse_ph    = xzisp_pkg::PH_INDICATOR;
		acc_val     = '0;
		acc_len     = 0;
		rec_want    = '0;
		rec_seen    = '0;
		odd_field   = 1'b0;
		size_acc    = '0;
		result_sent = 1'b0;
	endtask

	// Seven data bits per byte, low group first. A zero byte after the first,
	// or a continuation on the last allowed byte, is malformed.
	function automatic vstep_t take_group(input logic [7:0] b);
		if (acc_len >= VARINT_MAX)
			return VB_BAD;
		if (acc_len > 0 && b == IND_ZERO)
			return VB_BAD;
		acc_val = acc_val | (VALUE_W'(b[6:0]) << (7 * acc_len));
		acc_len++;
		if ((b & CONT_BIT) != 0) begin
			if (acc_len >= VARINT_MAX)
				return VB_BAD;
			return VB_MORE;
		end
		return VB_DONE;
	endfunction

	// Advances the mirror by one accepted byte and queues any result it causes.
	task automatic parse_index_byte(input logic [7:0] b, input logic lst);
		vstep_t             r;
		logic               hit;
		xzisp_pkg::status_t st;
		size_report_t       rep;
		hit = 1'b0;
		st  = xzisp_pkg::ST_OK;
		case (parse_ph)
			xzisp_pkg::PH_INDICATOR: begin
				if (b != IND_ZERO) begin
					hit = 1'b1;
					st  = xzisp_pkg::ST_BAD_IND;
				end else begin
					parse_ph = xzisp_pkg::PH_COUNT;
					acc_val  = '0;
					acc_len  = 0;
				end
			end
			xzisp_pkg::PH_COUNT, xzisp_pkg::PH_RECORDS: begin
				r = take_group(b);
				if (r == VB_BAD) begin
					hit = 1'b1;
					st  = xzisp_pkg::ST_BAD_VARINT;
				end else if (r == VB_DONE) begin
					if (parse_ph == xzisp_pkg::PH_COUNT) begin
						rec_want  = acc_val;
						rec_seen  = '0;
						odd_field = 1'b0;
						if (rec_want == 0)
							hit = 1'b1;
						else
							parse_ph = xzisp_pkg::PH_RECORDS;
					end else begin
						// unpadded size is dropped, uncompressed size is summed
						if (odd_field) begin
							size_acc = size_acc + SUM_W'(acc_val);
							rec_seen = rec_seen + VALUE_W'(1);
							if (rec_seen == rec_want)
								hit = 1'b1;
						end
						odd_field = ~odd_field;
					end
					acc_val = '0;
					acc_len = 0;
				end
			end
			default: ;
		endcase
		// stream ends before anything was reported
		if (!hit && lst && !result_sent) begin
			hit = 1'b1;
			st  = xzisp_pkg::ST_TRUNC;
		end
		if (hit) begin
			rep.total   = (st == xzisp_pkg::ST_OK) ? size_acc : '0;
			rep.records = (st == xzisp_pkg::ST_OK) ? rec_want : '0;
			rep.st      = st;
			reports_due.push_back(rep);
			result_sent = 1'b1;
			parse_ph    = xzisp_pkg::PH_DRAIN;
		end
		if (lst)
			clear_parser();
	endtask

	// ------------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------------
	function automatic logic [VALUE_W-1:0] rand_wide();
		logic [63:0] v;
		v = {$urandom, $urandom};
		v = v >> $urandom_range(1, 63);
		return v[VALUE_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 85) return VALUE_W'($urandom_range(1, 4));
		if (r < 92) return VALUE_W'($urandom_range(5, 6));
		return rand_wide();  // far too many records: stream gets cut short
	endfunction

	function automatic logic [VALUE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return VALUE_W'($urandom_range(0, 127));
		if (r < 70) return VALUE_W'($urandom_range(0, 2097151));
		if (r < 90) return rand_wide();
		return {VALUE_W{1'b1}};
	endfunction

	// Minimal encoding, with an occasional overlong run of continuation bytes.
	task automatic append_varint(input logic [VALUE_W-1:0] v);
		logic [6:0] grp;
		if ($urandom_range(0, 39) == 0) begin
			repeat ($urandom_range(VARINT_MAX, VARINT_MAX + 1))
				stream_bytes.push_back(CONT_BIT | 8'($urandom_range(0, 127)));
		end else begin
			do begin
				grp = v[6:0];
				v = v >> 7;
				stream_bytes.push_back({v != 0, grp});
			end while (v != 0);
		end
	endtask

	// Moves the scratch stream into the driver queue, last_byte on its end.
	task automatic flush_stream(input logic hold);
		index_beat_t beat;
		foreach (stream_bytes[i]) begin
			beat.data = stream_bytes[i];
			beat.last = (i == stream_bytes.size() - 1);
			beat.hold = hold && (i == 0);
			pending.push_back(beat);
		end
		stream_bytes.delete();
	endtask

	// Mostly well-formed indexes with random content; some get a bad
	// indicator, a zero byte dropped in, an early end, or are pure noise.
	task automatic add_random_stream(input logic hold);
		logic [VALUE_W-1:0] n;
		int                 recs;
		int                 kind;
		int                 cut;
		stream_bytes.push_back(IND_ZERO);
		n = pick_count();
		append_varint(n);
		recs = (n > 6) ? $urandom_range(0, 3) : int'(n);
		repeat (recs) begin
			append_varint(pick_size());
			append_varint(pick_size());
		end
		// padding / check bytes that the parser drains
		repeat ($urandom_range(0, 3))
			stream_bytes.push_back(8'($urandom_range(0, 255)));
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			stream_bytes[0] = 8'($urandom_range(1, 255));
		end else if (kind < 18) begin
			stream_bytes[$urandom_range(1, stream_bytes.size() - 1)] = IND_ZERO;
		end else if (kind < 28) begin
			cut = $urandom_range(0, stream_bytes.size() - 1);
			while (stream_bytes.size() > cut + 1)
				void'(stream_bytes.pop_back());
		end else if (kind < 33) begin
			stream_bytes.delete();
			repeat ($urandom_range(1, 8))
				stream_bytes.push_back(8'($urandom_range(0, 255)));
		end
		flush_stream(hold);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		// Directed streams.
		// bad indicator, ending on the same byte
		stream_bytes = '{8'hFF};
		flush_stream(1'b0);
		// stream ends on the indicator: truncated
		stream_bytes = '{8'h00};
		flush_stream(1'b0);
		// zero records, reported on the count byte that also ends the stream
		stream_bytes = '{8'h00, 8'h00};
		flush_stream(1'b0);
		// zero continuation byte inside the count; error wins over the end mark
		stream_bytes = '{8'h00, 8'h81, 8'h00};
		flush_stream(1'b0);
		// count keeps its continuation bit through all nine bytes, then a
		// byte that is only drained
		stream_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'h7F};
		flush_stream(1'b0);
		// one record (unpadded 128, uncompressed 127) plus a padding byte,
		// sent only after everything before it has been answered
		stream_bytes = '{8'h00, 8'h01, 8'h80, 8'h01, 8'h7F, 8'h5A};
		flush_stream(1'b1);

		// Random streams; now and then one waits for an empty pipeline.
		while (pending.size() < BYTE_TARGET)
			add_random_stream($urandom_range(0, 14) == 0);

		// Wait for the last byte to go in, then for every result.
		while (pending.size() != 0 || byte_valid)
			@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && reports_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, reports_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Idle pattern: mostly short gaps, a few long ones, and calm stretches
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calm <= 1'b0;
		end else if ($urandom_range(0, 149) == 0) begin
			calm <= ~calm;
		end
	end

	// ------------------------------------------------------------------------
	// Byte driver
	// ------------------------------------------------------------------------
	// A new byte goes out only when the slot is free. A hold byte also waits
	// for byte_valid to be low, so that in_flight already covers every accepted byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			index_byte <= '0;
			last_byte  <= 1'b0;
			send_gap   <= 0;
		end else if (!byte_valid || byte_ready) begin
			if (send_gap != 0) begin
				byte_valid <= 1'b0;
				send_gap   <= send_gap - 1;
			end else if (pending.size() != 0 &&
				(!pending[0].hold || (!byte_valid && in_flight == 0))) begin
				byte_valid <= 1'b1;
				index_byte <= pending[0].data;
				last_byte  <= pending[0].last;
				void'(pending.pop_front());
				send_gap   <= calm ? 0 : pick_gap();
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result sink: random stalls on result_ready
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(8, 30);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predicts on each input transaction, checks each result
	// transaction against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			reports_due.delete();
			in_flight <= 0;
		end else begin
			if (byte_valid && byte_ready)
				parse_index_byte(index_byte, last_byte);
			if (result_valid && result_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected result: total %h records %h status %0d",
						$time, total_size, record_total, status);
					fail_count++;
				end else begin
					report_head = reports_due.pop_front();
					if (status !== report_head.st) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, report_head.st, status);
						fail_count++;
					end
					if (total_size !== report_head.total) begin
						$display("%0t: total_size mismatch: expected %h, actual %h",
							$time, report_head.total, total_size);
						fail_count++;
					end
					if (record_total !== report_head.records) begin
						$display("%0t: record_total mismatch: expected %h, actual %h",
							$time, report_head.records, record_total);
						fail_count++;
					end
				end
			end
			in_flight <= reports_due.size();
		end
	end

endmodule
